// ===== rtl/range_scan_run_clustering_macros.svh =====
// Assertion macros used by the range scan run clustering RTL.
`ifndef RANGE_SCAN_RUN_CLUSTERING_MACROS_SVH
`define RANGE_SCAN_RUN_CLUSTERING_MACROS_SVH
`ifndef SYNTH
// Same-cycle implication, disabled while reset is high.
`define RSRC_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// Next-cycle implication, disabled while reset is high.
`define RSRC_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define RSRC_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define RSRC_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

// ===== rtl/rsrc_pkg.sv =====
// Package with the sizes, register codes and helpers of the range scan run clustering block.
package rsrc_pkg;

   localparam int SCAN_POINTS   = 512;
   localparam int CLUSTER_LIMIT = 32;

   localparam int IDX_W  = $clog2(SCAN_POINTS);
   localparam int CNT_W  = $clog2(SCAN_POINTS + 1);
   localparam int SUM_W  = $clog2(SCAN_POINTS * (SCAN_POINTS - 1) + 1);
   localparam int NUM_W  = SUM_W + 6;
   localparam int STEP_W = $clog2(NUM_W + 1);

   localparam int RNG_W      = 16;
   localparam int MINPTS_W   = 10;
   localparam int MAXCL_W    = 6;
   localparam int ANG_W      = 15;
   localparam int PCNT_W     = 10;
   localparam int CLNUM_W    = 5;
   localparam int TOT_W      = 6;
   localparam int LIM_W      = 7;
   localparam int CMP_W      = (CNT_W > MINPTS_W) ? CNT_W : MINPTS_W;
   localparam int ANGX_W     = (NUM_W > ANG_W) ? NUM_W : ANG_W;
   localparam int PCNTX_W    = (CNT_W > PCNT_W) ? CNT_W : PCNT_W;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_MIN_RANGE   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_RANGE   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_POINTS  = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_CLUSTER_CAP = 2'd3;

   localparam logic [RNG_W-1:0]    MIN_RANGE_RST   = 16'd150;
   localparam logic [RNG_W-1:0]    MAX_RANGE_RST   = 16'd3000;
   localparam logic [MINPTS_W-1:0] MIN_POINTS_RST  = 10'd3;
   localparam logic [MAXCL_W-1:0]  CLUSTER_CAP_RST = 6'd32;

   localparam logic [0:0] KIND_CLUSTER = 1'b0;
   localparam logic [0:0] KIND_SUMMARY = 1'b1;

   typedef logic [NUM_W-1:0] num_type;
   typedef logic [CNT_W-1:0] cnt_type;

   // Clamp the centroid quotient to the width of the angle field.
   function automatic logic [ANG_W-1:0] sat_angle(input num_type q);
      logic [ANGX_W-1:0] qx;
      qx = ANGX_W'(q);
      if (qx > ANGX_W'((2 ** ANG_W) - 1)) begin
         return '1;
      end
      return qx[ANG_W-1:0];
   endfunction

   // Clamp a run length to the width of the point count field.
   function automatic logic [PCNT_W-1:0] sat_count(input cnt_type c);
      logic [PCNTX_W-1:0] cx;
      cx = PCNTX_W'(c);
      if (cx > PCNTX_W'((2 ** PCNT_W) - 1)) begin
         return '1;
      end
      return cx[PCNT_W-1:0];
   endfunction

endpackage

// ===== rtl/range_scan_run_clustering.sv =====
// Top level of the range scan run clustering block: run tracking, sequencer and result register.
// Range samples arrive one beat at a time; runs of in-window samples are tracked and a run that
// qualifies is reported as a cluster whose angle is 36 * index sum / point count centidegrees,
// and the last sample of a scan is followed by a summary beat with the cluster total. A sample
// that reports nothing leaves the block idle, and the next beat is accepted straight after. A
// sample that reports a cluster runs the shared serial divider over NUM_W quotient bits (24 at the
// default 512 points per scan), one quotient bit per cycle, then delivers the cluster beat and,
// at a scan end, the summary beat. Each result beat is held in an output register until taken,
// and no new sample is accepted until all results of the current one have been delivered.
`include "range_scan_run_clustering_macros.svh"
module range_scan_run_clustering (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [rsrc_pkg::RNG_W-1:0]          req_range_mm,
   input  logic                                req_scan_end,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic                                rsp_kind,
   output logic [rsrc_pkg::ANG_W-1:0]          rsp_angle_centideg,
   output logic [rsrc_pkg::RNG_W-1:0]          rsp_nearest_mm,
   output logic [rsrc_pkg::PCNT_W-1:0]         rsp_point_count,
   output logic [rsrc_pkg::CLNUM_W-1:0]        rsp_cluster_number,
   output logic [rsrc_pkg::TOT_W-1:0]          rsp_cluster_total,
   output logic                                rsp_last_of_item,
   input  logic                                csr_we,
   input  logic [rsrc_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [rsrc_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import rsrc_pkg::*;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_DIV  = 2'd1;
   localparam logic [1:0] ST_CL   = 2'd2;
   localparam logic [1:0] ST_SUM  = 2'd3;

   logic [1:0]          state_ff, state_in;
   logic [RNG_W-1:0]    min_range_ff, min_range_in;
   logic [RNG_W-1:0]    max_range_ff, max_range_in;
   logic [MINPTS_W-1:0] min_points_ff, min_points_in;
   logic [MAXCL_W-1:0]  cluster_cap_ff, cluster_cap_in;

   logic                in_run_ff, in_run_in;
   logic [IDX_W-1:0]    sample_index_ff, sample_index_in;
   logic [SUM_W-1:0]    index_sum_ff, index_sum_in;
   cnt_type             run_points_ff, run_points_in;
   logic [RNG_W-1:0]    run_nearest_ff, run_nearest_in;
   logic [TOT_W-1:0]    clusters_found_ff, clusters_found_in;

   logic                pend_sum_ff, pend_sum_in;
   logic [TOT_W-1:0]    total_ff, total_in;
   logic [RNG_W-1:0]    pend_nearest_ff, pend_nearest_in;
   cnt_type             pend_count_ff, pend_count_in;
   logic [CLNUM_W-1:0]  pend_number_ff, pend_number_in;

   logic                rsp_kind_ff, rsp_kind_in;
   logic [ANG_W-1:0]    rsp_angle_ff, rsp_angle_in;
   logic [RNG_W-1:0]    rsp_nearest_ff, rsp_nearest_in;
   logic [PCNT_W-1:0]   rsp_count_ff, rsp_count_in;
   logic [CLNUM_W-1:0]  rsp_number_ff, rsp_number_in;
   logic [TOT_W-1:0]    rsp_total_ff, rsp_total_in;
   logic                rsp_last_ff, rsp_last_in;

   logic             accept;
   logic             sample_ok;
   logic             close_run;
   logic             qualify;
   logic [SUM_W-1:0] idx_ext;
   logic             run_new;
   logic [SUM_W-1:0] sum_new;
   cnt_type          pts_new;
   logic [RNG_W-1:0] near_new;
   logic [LIM_W-1:0] limit;
   logic [TOT_W-1:0] found_inc;
   num_type          dividend;
   logic             div_start;
   logic             div_done;
   num_type          div_quot;

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = (state_ff == ST_CL) || (state_ff == ST_SUM);
   assign accept    = req_valid && !req_stall;

   assign sample_ok = (req_range_mm > min_range_ff) && (req_range_mm <= max_range_ff);
   assign idx_ext   = SUM_W'(sample_index_ff);
   assign close_run = !sample_ok || req_scan_end;

   // Run state as it stands once this sample has been folded in.
   always_comb begin
      run_new  = in_run_ff;
      sum_new  = index_sum_ff;
      pts_new  = run_points_ff;
      near_new = run_nearest_ff;
      if (sample_ok) begin
         if (!in_run_ff) begin
            run_new  = 1'b1;
            sum_new  = idx_ext;
            pts_new  = CNT_W'(1);
            near_new = req_range_mm;
         end else begin
            if (req_range_mm < run_nearest_ff) begin
               near_new = req_range_mm;
            end
            // Beyond a full scan of points only the nearest range keeps moving.
            if (run_points_ff < CNT_W'(SCAN_POINTS)) begin
               sum_new = index_sum_ff + idx_ext;
               pts_new = run_points_ff + CNT_W'(1);
            end
         end
      end
   end

   assign limit = (LIM_W'(cluster_cap_ff) < LIM_W'(CLUSTER_LIMIT)) ?
                  LIM_W'(cluster_cap_ff) : LIM_W'(CLUSTER_LIMIT);

   assign qualify = close_run && run_new && (pts_new != '0) &&
                    (CMP_W'(pts_new) >= CMP_W'(min_points_ff)) &&
                    (LIM_W'(clusters_found_ff) < limit);

   assign found_inc = clusters_found_ff + TOT_W'(qualify);
   assign dividend  = (NUM_W'(sum_new) << 5) + (NUM_W'(sum_new) << 2);
   assign div_start = accept && qualify;

   rsrc_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (dividend),
      .divisor  (pts_new),
      .done     (div_done),
      .quotient (div_quot)
   );

   always_comb begin
      state_in          = state_ff;
      min_range_in      = min_range_ff;
      max_range_in      = max_range_ff;
      min_points_in     = min_points_ff;
      cluster_cap_in    = cluster_cap_ff;
      in_run_in         = in_run_ff;
      sample_index_in   = sample_index_ff;
      index_sum_in      = index_sum_ff;
      run_points_in     = run_points_ff;
      run_nearest_in    = run_nearest_ff;
      clusters_found_in = clusters_found_ff;
      pend_sum_in       = pend_sum_ff;
      total_in          = total_ff;
      pend_nearest_in   = pend_nearest_ff;
      pend_count_in     = pend_count_ff;
      pend_number_in    = pend_number_ff;
      rsp_kind_in       = rsp_kind_ff;
      rsp_angle_in      = rsp_angle_ff;
      rsp_nearest_in    = rsp_nearest_ff;
      rsp_count_in      = rsp_count_ff;
      rsp_number_in     = rsp_number_ff;
      rsp_total_in      = rsp_total_ff;
      rsp_last_in       = rsp_last_ff;

      if (csr_we) begin
         unique case (csr_index)
            CSR_MIN_RANGE:   min_range_in   = csr_wdata[RNG_W-1:0];
            CSR_MAX_RANGE:   max_range_in   = csr_wdata[RNG_W-1:0];
            CSR_MIN_POINTS:  min_points_in  = csr_wdata[MINPTS_W-1:0];
            CSR_CLUSTER_CAP: cluster_cap_in = csr_wdata[MAXCL_W-1:0];
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_scan_end) begin
                  sample_index_in = '0;
               end else if (sample_index_ff < IDX_W'(SCAN_POINTS - 1)) begin
                  sample_index_in = sample_index_ff + IDX_W'(1);
               end
               if (close_run) begin
                  in_run_in      = 1'b0;
                  index_sum_in   = '0;
                  run_points_in  = '0;
                  run_nearest_in = '0;
               end else begin
                  in_run_in      = run_new;
                  index_sum_in   = sum_new;
                  run_points_in  = pts_new;
                  run_nearest_in = near_new;
               end
               pend_sum_in       = req_scan_end;
               total_in          = found_inc;
               clusters_found_in = req_scan_end ? '0 : found_inc;
               if (qualify) begin
                  pend_nearest_in = near_new;
                  pend_count_in   = pts_new;
                  pend_number_in  = clusters_found_ff[CLNUM_W-1:0];
                  state_in        = ST_DIV;
               end else if (req_scan_end) begin
                  rsp_kind_in    = KIND_SUMMARY;
                  rsp_angle_in   = '0;
                  rsp_nearest_in = '0;
                  rsp_count_in   = '0;
                  rsp_number_in  = '0;
                  rsp_total_in   = found_inc;
                  rsp_last_in    = 1'b1;
                  state_in       = ST_SUM;
               end
            end
         end
         ST_DIV: begin
            if (div_done) begin
               rsp_kind_in    = KIND_CLUSTER;
               rsp_angle_in   = sat_angle(div_quot);
               rsp_nearest_in = pend_nearest_ff;
               rsp_count_in   = sat_count(pend_count_ff);
               rsp_number_in  = pend_number_ff;
               rsp_total_in   = '0;
               rsp_last_in    = !pend_sum_ff;
               state_in       = ST_CL;
            end
         end
         ST_CL: begin
            if (!rsp_stall) begin
               if (pend_sum_ff) begin
                  rsp_kind_in    = KIND_SUMMARY;
                  rsp_angle_in   = '0;
                  rsp_nearest_in = '0;
                  rsp_count_in   = '0;
                  rsp_number_in  = '0;
                  rsp_total_in   = total_ff;
                  rsp_last_in    = 1'b1;
                  state_in       = ST_SUM;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_SUM: begin
            if (!rsp_stall) begin
               state_in = ST_IDLE;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff          <= ST_IDLE;
         min_range_ff      <= MIN_RANGE_RST;
         max_range_ff      <= MAX_RANGE_RST;
         min_points_ff     <= MIN_POINTS_RST;
         cluster_cap_ff    <= CLUSTER_CAP_RST;
         in_run_ff         <= 1'b0;
         sample_index_ff   <= '0;
         index_sum_ff      <= '0;
         run_points_ff     <= '0;
         run_nearest_ff    <= '0;
         clusters_found_ff <= '0;
         pend_sum_ff       <= 1'b0;
      end else begin
         state_ff          <= state_in;
         min_range_ff      <= min_range_in;
         max_range_ff      <= max_range_in;
         min_points_ff     <= min_points_in;
         cluster_cap_ff    <= cluster_cap_in;
         in_run_ff         <= in_run_in;
         sample_index_ff   <= sample_index_in;
         index_sum_ff      <= index_sum_in;
         run_points_ff     <= run_points_in;
         run_nearest_ff    <= run_nearest_in;
         clusters_found_ff <= clusters_found_in;
         pend_sum_ff       <= pend_sum_in;
      end
      total_ff        <= total_in;
      pend_nearest_ff <= pend_nearest_in;
      pend_count_ff   <= pend_count_in;
      pend_number_ff  <= pend_number_in;
      rsp_kind_ff     <= rsp_kind_in;
      rsp_angle_ff    <= rsp_angle_in;
      rsp_nearest_ff  <= rsp_nearest_in;
      rsp_count_ff    <= rsp_count_in;
      rsp_number_ff   <= rsp_number_in;
      rsp_total_ff    <= rsp_total_in;
      rsp_last_ff     <= rsp_last_in;
   end

   assign rsp_kind           = rsp_kind_ff;
   assign rsp_angle_centideg = rsp_angle_ff;
   assign rsp_nearest_mm     = rsp_nearest_ff;
   assign rsp_point_count    = rsp_count_ff;
   assign rsp_cluster_number = rsp_number_ff;
   assign rsp_cluster_total  = rsp_total_ff;
   assign rsp_last_of_item   = rsp_last_ff;

   `RSRC_ASSERT_IMP(a_no_accept_with_result, clock, reset, rsp_valid, req_stall)
   `RSRC_ASSERT_IMP(a_div_done_in_div, clock, reset, div_done, state_ff == ST_DIV)
   `RSRC_ASSERT_NEXT(a_cluster_starts_div, clock, reset, div_start, state_ff == ST_DIV)
   `RSRC_ASSERT_IMP(a_summary_is_last, clock, reset, state_ff == ST_SUM, rsp_kind_ff && rsp_last_ff)
   `RSRC_ASSERT_IMP(a_idle_run_empty, clock, reset, !in_run_ff, run_points_ff == '0)

endmodule

// ===== rtl/rsrc_div.sv =====
// Restoring serial divider that produces one quotient bit per cycle.
module rsrc_div (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  rsrc_pkg::num_type dividend,
   input  rsrc_pkg::cnt_type divisor,
   output logic             done,
   output rsrc_pkg::num_type quotient
);
   import rsrc_pkg::*;

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [STEP_W-1:0] step_ff, step_in;
   num_type           quo_ff, quo_in;
   cnt_type           rem_ff, rem_in;
   cnt_type           den_ff, den_in;

   logic [CNT_W:0] rem_sh;
   logic [CNT_W:0] rem_diff;
   logic           take;

   assign rem_sh   = {rem_ff, quo_ff[NUM_W-1]};
   assign rem_diff = rem_sh - {1'b0, den_ff};
   assign take     = rem_sh >= {1'b0, den_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = STEP_W'(NUM_W);
         quo_in  = dividend;
         rem_in  = '0;
         den_in  = divisor;
      end else if (busy_ff) begin
         // The remainder stays below the divisor, so its top bit is always free.
         rem_in  = take ? rem_diff[CNT_W-1:0] : rem_sh[CNT_W-1:0];
         quo_in  = {quo_ff[NUM_W-2:0], take};
         step_in = step_ff - STEP_W'(1);
         if (step_ff == STEP_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// ===== sim/range_scan_run_clustering_test.sv =====
// Self-checking testbench for the range scan run clustering block.
module range_scan_run_clustering_test;
   import rsrc_pkg::*;

   localparam int RANGE_TOP = (1 << RNG_W) - 1;

   typedef struct packed {
      logic [0:0]          kind;
      logic [ANG_W-1:0]    angle;
      logic [RNG_W-1:0]    nearest;
      logic [PCNT_W-1:0]   points;
      logic [CLNUM_W-1:0]  number;
      logic [TOT_W-1:0]    total;
      logic                last;
   } cluster_beat_type;

   // Tracks runs the way the block should and holds the beats still owed by it.
   class scan_cluster_scoreboard;
      logic [RNG_W-1:0]    min_range;
      logic [RNG_W-1:0]    max_range;
      logic [MINPTS_W-1:0] min_points;
      logic [MAXCL_W-1:0]  cluster_cap;
      bit                  in_run;
      logic [IDX_W-1:0]    sample_index;
      logic [SUM_W-1:0]    index_sum;
      logic [CNT_W-1:0]    run_points;
      logic [RNG_W-1:0]    run_nearest;
      logic [TOT_W-1:0]    clusters_found;
      cluster_beat_type    awaited[$];
      cluster_beat_type    fresh[$];
      int                  mismatches;
      int                  samples_taken;
      int                  clusters_seen;
      int                  summaries_seen;

      function new();
         min_range      = MIN_RANGE_RST;
         max_range      = MAX_RANGE_RST;
         min_points     = MIN_POINTS_RST;
         cluster_cap    = CLUSTER_CAP_RST;
         in_run         = 1'b0;
         sample_index   = '0;
         index_sum      = '0;
         run_points     = '0;
         run_nearest    = '0;
         clusters_found = '0;
         mismatches     = 0;
         samples_taken  = 0;
         clusters_seen  = 0;
         summaries_seen = 0;
      endfunction

      // Ends the open run and queues a cluster beat if the run qualifies.
      function void close_run();
         int unsigned      cap;
         longint unsigned  quotient;
         cluster_beat_type beat;
         cap = (32'(cluster_cap) < CLUSTER_LIMIT) ? 32'(cluster_cap) : CLUSTER_LIMIT;
         if (in_run && run_points != 0 && run_points >= min_points && clusters_found < cap) begin
            quotient = (64'(index_sum) * 36) / run_points;
            beat = '0;
            beat.kind = KIND_CLUSTER;
            beat.angle = (quotient > (1 << ANG_W) - 1) ? '1 : ANG_W'(quotient);
            beat.nearest = run_nearest;
            beat.points = (run_points > (1 << PCNT_W) - 1) ? '1 : PCNT_W'(run_points);
            beat.number = clusters_found[CLNUM_W-1:0];
            fresh.push_back(beat);
            clusters_found = clusters_found + 1'b1;
         end
         in_run      = 1'b0;
         index_sum   = '0;
         run_points  = '0;
         run_nearest = '0;
      endfunction

      function void take_sample(logic [RNG_W-1:0] range_mm, logic scan_end);
         cluster_beat_type beat;
         samples_taken++;
         if (range_mm > min_range && range_mm <= max_range) begin
            if (!in_run) begin
               in_run      = 1'b1;
               index_sum   = '0;
               run_points  = '0;
               run_nearest = range_mm;
            end
            if (range_mm < run_nearest) run_nearest = range_mm;
            // Past SCAN_POINTS only the nearest range moves, so the mean stays put.
            if (run_points < SCAN_POINTS) begin
               index_sum  = index_sum + sample_index;
               run_points = run_points + 1'b1;
            end
         end else begin
            close_run();
         end
         if (sample_index < SCAN_POINTS - 1) sample_index = sample_index + 1'b1;
         if (scan_end) begin
            close_run();
            beat = '0;
            beat.kind = KIND_SUMMARY;
            beat.total = clusters_found;
            fresh.push_back(beat);
            sample_index   = '0;
            clusters_found = '0;
         end
         if (fresh.size() != 0) fresh[fresh.size() - 1].last = 1'b1;
         foreach (fresh[i]) awaited.push_back(fresh[i]);
         fresh.delete();
      endfunction

      function void check_beat(cluster_beat_type got);
         cluster_beat_type want;
         if (got.kind == KIND_SUMMARY) summaries_seen++;
         else clusters_seen++;
         if (awaited.size() == 0) begin
            if (mismatches < 10)
               $display("Unexpected result beat at %0t: kind %0d total %0d", $time,
                        got.kind, got.total);
            mismatches++;
            return;
         end
         want = awaited.pop_front();
         if (got !== want) begin
            if (mismatches < 10) begin
               $display("Result mismatch at %0t (expected/actual):", $time);
               $display("  kind %0d/%0d angle %0d/%0d nearest %0d/%0d points %0d/%0d",
                        want.kind, got.kind, want.angle, got.angle, want.nearest,
                        got.nearest, want.points, got.points);
               $display("  number %0d/%0d total %0d/%0d last %0d/%0d", want.number,
                        got.number, want.total, got.total, want.last, got.last);
            end
            mismatches++;
         end
      endfunction
   endclass

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic [RNG_W-1:0]      req_range_mm = '0;
   logic                  req_scan_end = 1'b0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic                  rsp_kind;
   logic [ANG_W-1:0]      rsp_angle_centideg;
   logic [RNG_W-1:0]      rsp_nearest_mm;
   logic [PCNT_W-1:0]     rsp_point_count;
   logic [CLNUM_W-1:0]    rsp_cluster_number;
   logic [TOT_W-1:0]      rsp_cluster_total;
   logic                  rsp_last_of_item;
   logic                  csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   scan_cluster_scoreboard sb;
   bit sender_eager = 1'b0;
   int hold_requests = 0;
   int holds_served = 0;
   int settings_used = 1;

   // Opening scan under the reset register values, then short scans around the edge cases.
   logic [RNG_W-1:0] dir_range [20] = '{16'd0, 16'd65535, 16'd150, 16'd151, 16'd3000,
                                        16'd2000, 16'd3001, 16'd400, 16'd500, 16'd150,
                                        16'd800, 16'd0, 16'd1000, 16'd900, 16'd1100,
                                        16'd1200, 16'd1000, 16'd1000, 16'd1000, 16'd0};
   logic             dir_last [20]  = '{1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
                                        1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
                                        1'b1, 1'b1, 1'b0, 1'b0, 1'b0,
                                        1'b1, 1'b0, 1'b0, 1'b0, 1'b1};

   logic [RNG_W-1:0]    phase_lo   [8] = '{16'd0, 16'd1000, 16'd65535, 16'd500,
                                           16'd200, 16'd300, 16'd2500, 16'd150};
   logic [RNG_W-1:0]    phase_hi   [8] = '{16'd65535, 16'd1200, 16'd0, 16'd500,
                                           16'd4000, 16'd5000, 16'd2600, 16'd3000};
   logic [MINPTS_W-1:0] phase_pts  [8] = '{10'd1, 10'd0, 10'd5, 10'd3,
                                           10'd1023, 10'd2, 10'd4, 10'd3};
   logic [MAXCL_W-1:0]  phase_clus [8] = '{6'd63, 6'd2, 6'd32, 6'd32,
                                           6'd32, 6'd0, 6'd1, 6'd32};

   range_scan_run_clustering dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_range_mm       (req_range_mm),
      .req_scan_end       (req_scan_end),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_kind           (rsp_kind),
      .rsp_angle_centideg (rsp_angle_centideg),
      .rsp_nearest_mm     (rsp_nearest_mm),
      .rsp_point_count    (rsp_point_count),
      .rsp_cluster_number (rsp_cluster_number),
      .rsp_cluster_total  (rsp_cluster_total),
      .rsp_last_of_item   (rsp_last_of_item),
      .csr_we             (csr_we),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic int pick_gap();
      int unsigned roll;
      roll = $urandom_range(99, 0);
      if (roll < 60) return 0;
      if (roll < 88) return $urandom_range(3, 1);
      if (roll < 97) return $urandom_range(10, 4);
      return $urandom_range(30, 15);
   endfunction

   // With an empty window every range is out of it, so any value will do.
   function automatic logic [RNG_W-1:0] pick_inside();
      int unsigned lo, hi, roll;
      lo = 32'(sb.min_range);
      hi = 32'(sb.max_range);
      roll = $urandom_range(9, 0);
      if (lo >= hi) return RNG_W'($urandom);
      if (roll == 0) return RNG_W'(lo + 1);
      if (roll == 1) return RNG_W'(hi);
      return RNG_W'($urandom_range(hi, lo + 1));
   endfunction

   function automatic logic [RNG_W-1:0] pick_outside();
      int unsigned lo, hi, roll;
      lo = 32'(sb.min_range);
      hi = 32'(sb.max_range);
      roll = $urandom_range(9, 0);
      if (lo >= hi) return RNG_W'($urandom);
      if (hi < RANGE_TOP && roll < 5)
         return (roll == 0) ? RNG_W'(hi + 1) : RNG_W'($urandom_range(RANGE_TOP, hi + 1));
      return (roll == 9) ? RNG_W'(lo) : RNG_W'($urandom_range(lo, 0));
   endfunction

   task automatic send_sample(input logic [RNG_W-1:0] range_mm, input logic scan_end);
      int gap;
      req_valid    <= 1'b1;
      req_range_mm <= range_mm;
      req_scan_end <= scan_end;
      do @(posedge clock); while (req_stall);
      sb.take_sample(range_mm, scan_end);
      gap = sender_eager ? 0 : pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Writes all four registers on consecutive edges; only called with the block idle.
   task automatic configure(input logic [RNG_W-1:0] lo, input logic [RNG_W-1:0] hi,
                            input logic [MINPTS_W-1:0] pts, input logic [MAXCL_W-1:0] clus);
      csr_we    <= 1'b1;
      csr_index <= CSR_MIN_RANGE;
      csr_wdata <= CSR_DATA_W'(lo);
      @(posedge clock);
      csr_index <= CSR_MAX_RANGE;
      csr_wdata <= CSR_DATA_W'(hi);
      @(posedge clock);
      csr_index <= CSR_MIN_POINTS;
      csr_wdata <= CSR_DATA_W'(pts);
      @(posedge clock);
      csr_index <= CSR_CLUSTER_CAP;
      csr_wdata <= CSR_DATA_W'(clus);
      @(posedge clock);
      csr_we <= 1'b0;
      sb.min_range   = lo;
      sb.max_range   = hi;
      sb.min_points  = pts;
      sb.cluster_cap = clus;
      settings_used++;
   endtask

   // Waits for every owed beat, then lets the divider settle before anything else changes.
   task automatic drain();
      req_valid <= 1'b0;
      while (sb.awaited.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   // Mostly whole scans built from runs and gaps; now and then a burst of arbitrary samples.
   task automatic send_scans(input int budget, input int longest);
      int               sent;
      int               run_len;
      int               scan_len;
      logic [RNG_W-1:0] scan[$];
      sent = 0;
      while (sent < budget) begin
         sender_eager = ($urandom_range(4, 0) == 0);
         if ($urandom_range(99, 0) < 12) begin
            repeat ($urandom_range(12, 1)) begin
               send_sample(RNG_W'($urandom), $urandom_range(7, 0) == 0);
               sent++;
            end
         end else begin
            scan.delete();
            scan_len = $urandom_range(longest, 1);
            while (scan.size() < scan_len) begin
               run_len = ($urandom_range(9, 0) == 0) ? $urandom_range(24, 6)
                                                     : $urandom_range(5, 1);
               repeat (run_len) scan.push_back(pick_inside());
               repeat ($urandom_range(3, 1)) scan.push_back(pick_outside());
               if ($urandom_range(3, 0) == 0) scan.delete(scan.size() - 1);
            end
            foreach (scan[i]) begin
               send_sample(scan[i], i == scan.size() - 1);
               sent++;
            end
         end
      end
      sender_eager = 1'b0;
   endtask

   initial begin : result_side
      int          hold_left;
      int          quiet_left;
      int unsigned roll;
      hold_left  = 0;
      quiet_left = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall)
            sb.check_beat({rsp_kind, rsp_angle_centideg, rsp_nearest_mm, rsp_point_count,
                           rsp_cluster_number, rsp_cluster_total, rsp_last_of_item});
         // A requested hold-off stalls results long enough for the input side to back up.
         if (holds_served != hold_requests) begin
            holds_served = hold_requests;
            hold_left    = 300;
            quiet_left   = 0;
         end
         if (hold_left == 0 && quiet_left == 0) begin
            roll = $urandom_range(99, 0);
            if (roll < 27) hold_left = $urandom_range(3, 1);
            else if (roll < 30) hold_left = $urandom_range(40, 10);
            else if (roll < 93) quiet_left = $urandom_range(12, 1);
            else quiet_left = $urandom_range(150, 60);
         end
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else begin
            rsp_stall <= 1'b0;
            quiet_left--;
         end
      end
   end

   initial begin
      #9_600_000;
      $display("Run timed out with %0d result beats still owed.", sb.awaited.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin
      sb = new();
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      foreach (dir_range[i]) send_sample(dir_range[i], dir_last[i]);
      drain();

      for (int p = 0; p < 8; p++) begin
         configure(phase_lo[p], phase_hi[p], phase_pts[p], phase_clus[p]);
         if (p < 2) hold_requests++;
         // The wide open window gets long scans so that the cluster limit is reached.
         send_scans(140, (p == 0) ? 200 : 48);
         drain();
      end

      // An overlong scan holding one overlong run: the sample index and the point count
      // both saturate, and exactly SCAN_POINTS points still qualify.
      configure(16'd100, 16'd2000, 10'd512, 6'd1);
      // The last phase may have left a scan open, so end it before the limit of one applies.
      send_sample(pick_outside(), 1'b1);
      repeat (5) send_sample(pick_outside(), 1'b0);
      for (int k = 0; k < 520; k++) send_sample(pick_inside(), k == 519);
      send_scans(60, 48);
      drain();

      $display("Run covered %0d samples under %0d register settings, with an overlong scan",
               sb.samples_taken, settings_used);
      $display("and long result hold-offs; %0d cluster beats and %0d scan summaries checked.",
               sb.clusters_seen, sb.summaries_seen);
      if (sb.mismatches == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("%0d result beats were wrong or unexpected.", sb.mismatches);
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
